### rtl/core/assert_macros.svh
// Assertion macros shared by the frame time averager RTL.
// Included by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FTA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/fta_pkg.sv
// Shared constants and types for the frame time averager.
// No dependencies; imported by every other RTL file of the block but fta_ram.
package fta_pkg;

  // Averaging window
  localparam int unsigned WinDepth = 64;
  localparam int unsigned AddrW    = (WinDepth > 1) ? $clog2(WinDepth) : 1;
  localparam int unsigned CountW   = $clog2(WinDepth + 1);

  // Time and sum widths
  localparam int unsigned TsW       = 32;
  localparam int unsigned SumW      = TsW + AddrW;
  localparam int unsigned RateTimeW = TsW + 2;
  localparam int unsigned RateW     = 20;
  localparam int unsigned DivCntW   = $clog2(SumW);

  localparam logic [RateW-1:0] RateMax  = {RateW{1'b1}};
  localparam logic [TsW-1:0]   TpsReset = TsW'(1000000);

  // Status of the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/core/fta_in_if.sv
// Input channel of the frame time averager: one frame event per transfer.
// Depends on fta_pkg for the timestamp width.
interface fta_in_if;
  import fta_pkg::*;

  logic           valid;
  logic           ready;
  logic [TsW-1:0] frame_timestamp;

  modport source (output valid, output frame_timestamp, input ready);
  modport sink   (input valid, input frame_timestamp, output ready);
endinterface

### rtl/core/fta_out_if.sv
// Result channel of the frame time averager: one result per transfer.
// Depends on fta_pkg for field widths.
interface fta_out_if;
  import fta_pkg::*;

  logic              valid;
  logic              ready;
  logic [TsW-1:0]    elapsed_ticks;
  logic              sample_accepted;
  logic [TsW-1:0]    average_ticks;
  logic [CountW-1:0] sample_count;
  logic [RateW-1:0]  frame_rate;

  modport source (output valid, output elapsed_ticks, output sample_accepted,
                  output average_ticks, output sample_count, output frame_rate,
                  input ready);
  modport sink   (input valid, input elapsed_ticks, input sample_accepted,
                  input average_ticks, input sample_count, input frame_rate,
                  output ready);
endinterface

### rtl/core/fta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fta_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/fta_div.sv
// Bit-serial restoring divider: window sum over sample count.
// Depends on fta_pkg; one quotient bit per cycle.
module fta_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fta_pkg::SumW-1:0]  dividend_i,
  input  logic [fta_pkg::CountW-1:0] divisor_i,
  output fta_pkg::div_stat_t        stat_o,
  output logic [fta_pkg::TsW-1:0]   quotient_o
);
  import fta_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [SumW-1:0]   dvd_q;
  logic [CountW-1:0] rem_q;
  logic [CountW-1:0] dvs_q;
  logic [CountW:0]   trial;
  logic [CountW:0]   trial_diff;
  logic              qbit;

  // Shift in the next dividend bit and try the subtraction
  assign trial      = {rem_q, dvd_q[SumW-1]};
  assign trial_diff = trial - {1'b0, dvs_q};
  assign qbit       = (trial >= {1'b0, dvs_q});

  // Control: count the bits of one division
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(SumW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[SumW-2:0], qbit};
      rem_q <= qbit ? trial_diff[CountW-1:0] : trial[CountW-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dvd_q[TsW-1:0];

endmodule

### rtl/core/frame_time_averager.sv
// Frame time averager: moving average of frame times with a frame rate counter.
// Depends on fta_pkg, fta_in_if, fta_out_if, fta_ram, fta_div and assert_macros.svh.
//
// Usage:
//   in_i carries one frame event per transfer (frame_timestamp, a free-running
//   counter). out_o returns one result per event: elapsed ticks, whether the
//   frame time entered the window, the window average, the sample count and
//   the latched frame rate. cfg_we_i / cfg_wdata_i write ticks_per_second;
//   write it only while no event is in flight.
// Sequencing:
//   The first event after reset goes from S_IDLE straight to S_DONE. Later
//   events pass S_DIFF, S_TEST and S_UPD; a rejected frame time then goes to
//   S_DONE, an accepted one on through S_SUM and S_DIV, where it waits for the
//   bit-serial divider. in_i is ready only in S_IDLE, so the block takes no new
//   event until the last one is through. Each result reaches out_o in the same
//   cycle that in_i is ready again.
// Reset:
//   Clears the window, the sum, the average and the rate counters; the
//   ticks_per_second register returns to 1000000. The window RAM needs no
//   clearing: its read data is used only once the window is full.
// Stalls:
//   A finished result waits in the output register; the next event is taken
//   meanwhile, and its result holds until the register is free.
`include "assert_macros.svh"

module frame_time_averager (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [fta_pkg::TsW-1:0] cfg_wdata_i,
  fta_in_if.sink                  in_i,
  fta_out_if.source               out_o
);
  import fta_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;
  localparam logic [2:0] S_TEST = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [CountW-1:0] FillMax = CountW'(WinDepth);
  localparam logic [AddrW-1:0]  HeadMax = AddrW'(WinDepth - 1);

  logic [2:0]          state_q, state_d;
  logic [TsW-1:0]      tps_q;
  logic [TsW-1:0]      ref_q;
  logic                primed_q;
  logic [AddrW-1:0]    head_q;
  logic [CountW-1:0]   fill_q;
  logic [SumW-1:0]     sum_q;
  logic [TsW-1:0]      avg_q;
  logic [RateW-1:0]    rate_frames_q;
  logic [RateTimeW-1:0] rate_time_q;
  logic [RateW-1:0]    latched_q;
  logic                out_valid_q;

  logic [TsW-1:0]      elapsed_q;
  logic [TsW-1:0]      diff_q;
  logic                acc_q;

  logic [TsW-1:0]      out_elapsed_q;
  logic                out_acc_q;
  logic [TsW-1:0]      out_avg_q;
  logic [CountW-1:0]   out_count_q;
  logic [RateW-1:0]    out_rate_q;

  logic                in_xfer;
  logic                out_load;
  logic [TsW:0]        ea_diff;
  logic [TsW-1:0]      ae_diff;
  logic [SumW-1:0]     sum_add;
  logic [TsW-1:0]      ram_rdata;
  logic                div_start;
  div_stat_t           div_stat;
  logic [TsW-1:0]      div_quot;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && (state_q == S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // Distance of the frame time from the average, both ways round
  assign ea_diff   = {1'b0, elapsed_q} - {1'b0, avg_q};
  assign ae_diff   = avg_q - elapsed_q;
  assign sum_add   = sum_q + SumW'(elapsed_q);
  assign div_start = (state_q == S_SUM);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = primed_q ? S_DIFF : S_DONE;
        end
      end
      S_DIFF: state_d = S_TEST;
      S_TEST: state_d = S_UPD;
      S_UPD:  state_d = acc_q ? S_SUM : S_DONE;
      S_SUM:  state_d = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      tps_q         <= TpsReset;
      ref_q         <= '0;
      primed_q      <= 1'b0;
      head_q        <= '0;
      fill_q        <= '0;
      sum_q         <= '0;
      avg_q         <= '0;
      rate_frames_q <= '0;
      rate_time_q   <= '0;
      latched_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            ref_q    <= in_i.frame_timestamp;
            primed_q <= 1'b1;
          end
        end
        S_DIFF: begin
          // Count the frame toward the rate
          if (rate_frames_q != RateMax) begin
            rate_frames_q <= rate_frames_q + 1'b1;
          end
          rate_time_q <= rate_time_q + RateTimeW'(elapsed_q);
        end
        S_TEST: begin
          // Latch the rate once a second has gone by
          if (rate_time_q > RateTimeW'(tps_q)) begin
            latched_q     <= rate_frames_q;
            rate_frames_q <= '0;
            rate_time_q   <= '0;
          end
        end
        S_UPD: begin
          // Replace the oldest entry or grow the window
          if (acc_q) begin
            if (fill_q == FillMax) begin
              sum_q <= sum_q - SumW'(ram_rdata);
            end else begin
              fill_q <= fill_q + 1'b1;
            end
            head_q <= (head_q == HeadMax) ? '0 : head_q + 1'b1;
          end
        end
        S_SUM: sum_q <= sum_add;
        S_DIV: begin
          if (div_stat.done) begin
            avg_q <= div_quot;
          end
        end
        default: ;
      endcase
      // Output register: load a result, drop it once transferred
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-frame working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          elapsed_q <= primed_q ? (in_i.frame_timestamp - ref_q) : '0;
          acc_q     <= 1'b0;
        end
      end
      S_DIFF: diff_q <= ea_diff[TsW] ? ae_diff : ea_diff[TsW-1:0];
      S_TEST: acc_q  <= (diff_q < tps_q);
      default: ;
    endcase
    if (out_load) begin
      out_elapsed_q <= elapsed_q;
      out_acc_q     <= acc_q;
      out_avg_q     <= avg_q;
      out_count_q   <= fill_q;
      out_rate_q    <= latched_q;
    end
  end

  fta_ram #(
    .Width (TsW),
    .Depth (WinDepth)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_UPD) && acc_q),
    .waddr_i (head_q),
    .wdata_i (elapsed_q),
    .re_i    (state_q == S_TEST),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  fta_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_add),
    .divisor_i  (fill_q),
    .stat_o     (div_stat),
    .quotient_o (div_quot)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.elapsed_ticks   = out_elapsed_q;
  assign out_o.sample_accepted = out_acc_q;
  assign out_o.average_ticks   = out_avg_q;
  assign out_o.sample_count    = out_count_q;
  assign out_o.frame_rate      = out_rate_q;

  `FTA_ASSERT_ALWAYS(a_fill_bound, clk_i, fill_q <= FillMax, "window fill beyond depth")
  `FTA_ASSERT(a_head_track, clk_i, rst_ni, (fill_q != FillMax) |-> (head_q == fill_q[AddrW-1:0]), "head out of step with fill")
  `FTA_ASSERT(a_sum_only_accepted, clk_i, rst_ni, (state_q == S_SUM) |-> (acc_q && (fill_q != '0)), "sum update without an accepted sample")
  `FTA_ASSERT(a_div_done_in_div, clk_i, rst_ni, div_stat.done |-> (state_q == S_DIV), "divider finished outside its wait state")

endmodule
